@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file tach_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/tach_pkg.sv @@
`default_nettype none

package tach_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int MASK_W       = 2;
  localparam int STAMP_W      = 32;
  localparam int TICKS_W      = 16;
  localparam int CFG_W        = 32;
  localparam int DIV_CNT_W    = $clog2(STAMP_W);

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd250;
  localparam logic [STAMP_W-1:0] NUMER_RESET = 32'd20000000;

  // configuration register indexes
  localparam logic CFG_TICKS = 1'b0;
  localparam logic CFG_NUMER = 1'b1;

  typedef struct packed {
    logic [MASK_W-1:0]  edge_mask;
    logic [STAMP_W-1:0] timestamp;
  } event_t;

  typedef struct packed {
    logic               channel;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] speed;
    logic               last;
  } result_t;

  typedef struct packed {
    logic               start;
    logic [STAMP_W-1:0] dividend;
    logic [STAMP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [STAMP_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PICK = 5'b00010,
    ST_DIVP = 5'b00100,
    ST_DIVS = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/tach_divider.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
// a zero divisor gives a quotient of all ones
module tach_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tach_pkg::div_req_t req,
  output tach_pkg::div_rsp_t      rsp
);

  localparam int W  = tach_pkg::STAMP_W;
  localparam int CW = tach_pkg::DIV_CNT_W;

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         fits;

  assign shifted = {rem, quo[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};
  assign fits    = ~diff[W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[W-1:0];
      end else begin
        rem <= shifted[W-1:0];
      end
      quo <= {quo[W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

@@ rtl/dual_tachometer_period_speed.sv @@
// Period and speed measurement for two tachometer channels.
// An event arrives on event_valid/event_data/event_stall: a mask of channels
// that saw a rising edge and the down-counting timer value. For each channel
// in the mask, channel 1 first, one result leaves on
// result_valid/result_data/result_stall with the channel, the period
// (elapsed ticks / ticks_per_unit) and the speed (speed_numerator / period);
// last is set on the final result of the event. An empty mask gives nothing.
// Both divisions run on one shared 32-step restoring divider. event_stall
// is high from the transfer of an event until the cycle after its final
// result is loaded into the output register. A stalled receiver holds the
// output register; the sequencer waits before loading a further result and
// can take the next event once it has gone from the emit state through the
// pick state back to idle. cfg_we/cfg_index/cfg_data write ticks_per_unit
// (index 0) and speed_numerator (index 1); the user must write them only
// while idle, as the block itself does not enforce this.
// Reset (rst, synchronous) restores 250 and 20000000, clears both stored
// timestamps to zero and empties the output register.
`default_nettype none

module dual_tachometer_period_speed (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [tach_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         event_valid,
  output logic                              event_stall,
  input  wire tach_pkg::event_t             event_data,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output tach_pkg::result_t                 result_data
);

  localparam int W = tach_pkg::STAMP_W;

  tach_pkg::state_t state, state_next;

  logic [tach_pkg::TICKS_W-1:0] ticks_per_unit;
  logic [W-1:0]                 speed_numerator;
  logic [W-1:0]                 last_stamp [tach_pkg::NUM_CHANNELS];

  logic [tach_pkg::MASK_W-1:0]  pending, pending_next;
  logic [W-1:0]                 now_stamp, now_stamp_next;
  logic                         cur_ch, cur_ch_next;
  logic                         cur_last, cur_last_next;
  logic [W-1:0]                 period, period_next;

  logic                         sel_ch;
  logic [W-1:0]                 elapsed;
  logic                         stamp_we;
  logic                         load;

  tach_pkg::div_req_t div_req;
  tach_pkg::div_rsp_t div_rsp;

  tach_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // highest pending channel goes first
  assign sel_ch  = pending[1];
  assign elapsed = last_stamp[sel_ch] - now_stamp;

  always_comb begin
    state_next       = state;
    pending_next     = pending;
    now_stamp_next   = now_stamp;
    cur_ch_next      = cur_ch;
    cur_last_next    = cur_last;
    period_next      = period;
    stamp_we         = 1'b0;
    load             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = elapsed;
    div_req.divisor  = {{(W - tach_pkg::TICKS_W){1'b0}}, ticks_per_unit};
    case (state)
      tach_pkg::ST_IDLE: begin
        if (event_valid) begin
          pending_next   = event_data.edge_mask;
          now_stamp_next = event_data.timestamp;
          state_next     = tach_pkg::ST_PICK;
        end
      end
      tach_pkg::ST_PICK: begin
        if (pending == '0) begin
          state_next = tach_pkg::ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          stamp_we      = 1'b1;
          cur_ch_next   = sel_ch;
          cur_last_next = sel_ch ? ~pending[0] : 1'b1;
          pending_next  = sel_ch ? {1'b0, pending[0]} : 2'b00;
          state_next    = tach_pkg::ST_DIVP;
        end
      end
      tach_pkg::ST_DIVP: begin
        if (div_rsp.done) begin
          period_next      = div_rsp.quotient;
          div_req.start    = 1'b1;
          div_req.dividend = speed_numerator;
          div_req.divisor  = div_rsp.quotient;
          state_next       = tach_pkg::ST_DIVS;
        end
      end
      tach_pkg::ST_DIVS: begin
        if (div_rsp.done) begin
          state_next = tach_pkg::ST_EMIT;
        end
      end
      tach_pkg::ST_EMIT: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = tach_pkg::ST_PICK;
        end
      end
      default: begin
        state_next = tach_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tach_pkg::ST_IDLE;
      pending         <= '0;
      result_valid    <= 1'b0;
      ticks_per_unit  <= tach_pkg::TICKS_RESET;
      speed_numerator <= tach_pkg::NUMER_RESET;
      for (int c = 0; c < tach_pkg::NUM_CHANNELS; c++) begin
        last_stamp[c] <= '0;
      end
    end else begin
      state   <= state_next;
      pending <= pending_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          tach_pkg::CFG_TICKS: ticks_per_unit  <= cfg_data[tach_pkg::TICKS_W-1:0];
          tach_pkg::CFG_NUMER: speed_numerator <= cfg_data;
          default: begin
          end
        endcase
      end
      if (stamp_we) begin
        last_stamp[sel_ch] <= now_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_stamp <= now_stamp_next;
    cur_ch    <= cur_ch_next;
    cur_last  <= cur_last_next;
    period    <= period_next;
    if (load) begin
      result_data.channel <= cur_ch;
      result_data.period  <= period;
      result_data.speed   <= div_rsp.quotient;
      result_data.last    <= cur_last;
    end
  end

  assign event_stall = (state != tach_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/tach_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module tach_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              event_valid,
  input wire logic              event_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire tach_pkg::result_t result_data
);

  // a result held by the receiver stays put
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result_data))

  // an event transfer always starts a busy phase
  `ASSERT_NEXT(a_busy_after_event, clk, rst, event_valid && !event_stall, event_stall)

  // zero period saturates the speed
  `ASSERT_SAME(a_zero_period, clk, rst, result_valid && (result_data.period == '0), result_data.speed == '1)

endmodule

bind dual_tachometer_period_speed tach_checker u_tach_checker (
  .clk          (clk),
  .rst          (rst),
  .event_valid  (event_valid),
  .event_stall  (event_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

`default_nettype wire

@@ sim/tb_dual_tachometer_period_speed.sv @@
`timescale 1ns / 1ps

module tb_dual_tachometer_period_speed;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic                            cfg_index;
  logic [tach_pkg::CFG_W-1:0]      cfg_data;
  logic                            event_valid;
  logic                            event_stall;
  tach_pkg::event_t                event_data;
  logic                            result_valid;
  logic                            result_stall;
  tach_pkg::result_t               result_data;

  // model copy of the block's registers and stored edge times
  logic [tach_pkg::TICKS_W-1:0]    tick_div;
  logic [tach_pkg::STAMP_W-1:0]    speed_num;
  logic [tach_pkg::STAMP_W-1:0]    prev_stamp [tach_pkg::NUM_CHANNELS];

  tach_pkg::result_t               expected_results [$];
  tach_pkg::result_t               want_result;
  int                              mismatch_count;
  int                              send_pct;
  int                              recv_pct;

  dual_tachometer_period_speed u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_data   (event_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < recv_pct);
  end

  // elapsed ticks, period and speed for every channel that fired, highest first
  function automatic void predict_measurements(input tach_pkg::event_t ev);
    tach_pkg::result_t                 meas [2];
    int                                n_meas;
    logic [tach_pkg::STAMP_W-1:0]      elapsed;
    logic [tach_pkg::STAMP_W-1:0]      period_q;
    logic [tach_pkg::STAMP_W-1:0]      speed_q;
    n_meas = 0;
    for (int c = tach_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
      if (c < tach_pkg::MASK_W && ev.edge_mask[c]) begin
        elapsed = prev_stamp[c] - ev.timestamp;
        if (tick_div == '0) period_q = '1;
        else period_q = elapsed /
                        {{(tach_pkg::STAMP_W-tach_pkg::TICKS_W){1'b0}}, tick_div};
        if (period_q == '0) speed_q = '1;
        else speed_q = speed_num / period_q;
        prev_stamp[c] = ev.timestamp;
        if (n_meas < 2) begin
          meas[n_meas].channel = c[0];
          meas[n_meas].period  = period_q;
          meas[n_meas].speed   = speed_q;
          meas[n_meas].last    = 1'b0;
          n_meas++;
        end
      end
    end
    for (int i = 0; i < n_meas; i++) begin
      meas[i].last = (i == n_meas - 1);
      expected_results.push_back(meas[i]);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: channel %0d period %0h speed %0h last %0b",
               result_data.channel, result_data.period, result_data.speed,
               result_data.last);
        mismatch_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (result_data.channel !== want_result.channel) begin
          $error("channel: expected %0d, got %0d", want_result.channel,
                 result_data.channel);
          mismatch_count++;
        end
        if (result_data.period !== want_result.period) begin
          $error("period: expected %0h, got %0h", want_result.period, result_data.period);
          mismatch_count++;
        end
        if (result_data.speed !== want_result.speed) begin
          $error("speed: expected %0h, got %0h", want_result.speed, result_data.speed);
          mismatch_count++;
        end
        if (result_data.last !== want_result.last) begin
          $error("last: expected %0b, got %0b", want_result.last, result_data.last);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_event(input logic [tach_pkg::MASK_W-1:0] mask,
                            input logic [tach_pkg::STAMP_W-1:0] stamp);
    tach_pkg::event_t ev;
    ev.edge_mask = mask;
    ev.timestamp = stamp;
    if ($urandom_range(99) < send_pct) begin
      event_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    event_valid <= 1'b1;
    event_data  <= ev;
    do @(posedge clk); while (event_stall);
    predict_measurements(ev);
  endtask

  // hold off the sender until the block has delivered everything
  task automatic wait_results_done();
    int guard;
    event_valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [tach_pkg::CFG_W-1:0] ticks_word,
                            input logic [tach_pkg::CFG_W-1:0] numer_word);
    cfg_we    <= 1'b1;
    cfg_index <= tach_pkg::CFG_TICKS;
    cfg_data  <= ticks_word;
    @(posedge clk);
    cfg_index <= tach_pkg::CFG_NUMER;
    cfg_data  <= numer_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tick_div  = ticks_word[tach_pkg::TICKS_W-1:0];
    speed_num = numer_word;
  endtask

  // default registers, stored times cleared by reset
  task automatic test_reset_defaults();
    send_event(2'b00, 32'h1234_5678);
    send_event(2'b11, 32'h0000_0000);
    send_event(2'b01, 32'hFFFF_9E58);
    send_event(2'b10, 32'hFFFF_FFFF);
    send_event(2'b11, 32'hFF00_0000);
    send_event(2'b00, 32'h0000_0000);
    wait_results_done();
  endtask

  // counter wrap and equal timestamps
  task automatic test_timer_wrap();
    send_event(2'b11, 32'h0000_0010);
    send_event(2'b11, 32'h8000_0000);
    send_event(2'b01, 32'hFFFF_FFFF);
    send_event(2'b10, 32'hFFFF_FFFF);
    send_event(2'b11, 32'hFFFF_FFFF);
    send_event(2'b11, 32'h0000_0000);
    wait_results_done();
  endtask

  task automatic test_divisor_extremes();
    set_config(32'd1, 32'hFFFF_FFFF);
    send_event(2'b11, 32'hFFFF_FFF0);
    send_event(2'b11, 32'h7FFF_FFF0);
    wait_results_done();
    // upper bits dropped, divisor becomes zero
    set_config(32'hABCD_0000, 32'd20000000);
    send_event(2'b11, 32'h7000_0000);
    send_event(2'b01, 32'h6000_0000);
    wait_results_done();
    set_config(32'hFFFF_FFFF, 32'd1);
    send_event(2'b11, 32'h0000_0000);
    send_event(2'b10, 32'hFFFF_0000);
    wait_results_done();
    set_config(32'd250, 32'd0);
    send_event(2'b11, 32'hFFF0_0000);
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int                              fired;
    int                              pick;
    logic [tach_pkg::STAMP_W-1:0]    timer;
    logic [tach_pkg::STAMP_W-1:0]    delta;
    send_pct = s_pct;
    recv_pct = r_pct;
    fired = 0;
    timer = $urandom;
    while (fired < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_event(2'b00, $urandom);
      end else if (pick < 12) begin
        send_event(tach_pkg::MASK_W'($urandom_range(1, 3)), $urandom);
        fired++;
      end else begin
        case ($urandom_range(3))
          0: delta = $urandom_range(2000);
          1: delta = $urandom_range(32'h0010_0000);
          2: delta = $urandom_range(32'h0FFF_FFFF);
          default: delta = $urandom;
        endcase
        timer = timer - delta;
        send_event(tach_pkg::MASK_W'($urandom_range(1, 3)), timer);
        fired++;
      end
      if (fired == n_items / 2 && pick >= 5) begin
        wait_results_done();
        set_config($urandom_range(1, 2000), $urandom);
      end
    end
    wait_results_done();
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = tach_pkg::CFG_TICKS;
    cfg_data       = '0;
    event_valid    = 1'b0;
    event_data     = '0;
    result_stall   = 1'b0;
    mismatch_count = 0;
    send_pct       = 10;
    recv_pct       = 58;
    tick_div       = tach_pkg::TICKS_RESET;
    speed_num      = tach_pkg::NUMER_RESET;
    for (int c = 0; c < tach_pkg::NUM_CHANNELS; c++) prev_stamp[c] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_timer_wrap();
    test_divisor_extremes();
    set_config({{(tach_pkg::CFG_W-tach_pkg::TICKS_W){1'b0}}, tach_pkg::TICKS_RESET},
               tach_pkg::NUMER_RESET);
    test_random_traffic(10, 58, 520);
    set_config($urandom_range(1, 65535), $urandom);
    test_random_traffic(58, 10, 520);
    set_config(32'd65535, 32'hFFFF_FFFF);
    test_random_traffic(0, 0, 530);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_dual_tachometer_period_speed: PASS");
    end else begin
      $display("tb_dual_tachometer_period_speed: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_dual_tachometer_period_speed: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tach_pkg.sv
rtl/tach_divider.sv
rtl/dual_tachometer_period_speed.sv
rtl/tach_checker.sv
sim/tb_dual_tachometer_period_speed.sv
